@@ rtl/core/fspa_pkg.sv @@
package fspa_pkg;

   // Pool geometry.
   localparam int MAX_SLOTS  = 1024;
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int CHUNK_W    = 16;
   localparam int OFS_W      = 26;
   localparam int MIN_STRIDE = 8;
   localparam int LINK_W     = SLOT_W + 1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT  = 1'd1;

   // Configuration reset values.
   localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(8);
   localparam logic [CNT_W-1:0]   LIMIT_RESET = CNT_W'(MAX_SLOTS);

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_EXHAUSTED = 2'd1;
   localparam logic [1:0] ERR_NONE_USED = 2'd2;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   // Write request into the link memory.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [LINK_W-1:0] data;
   } link_wr_type;

   // Read request into the link memory.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } link_rd_type;

endpackage

@@ rtl/core/fspa_link_ram.sv @@
module fspa_link_ram (
   input  logic                             clock,
   input  fspa_pkg::link_wr_type            wr,
   input  fspa_pkg::link_rd_type            rd,
   output logic [fspa_pkg::LINK_W-1:0]      rd_data
);

   // One link word per slot: bit SLOT_W flags a following free slot.
   logic [fspa_pkg::LINK_W-1:0] mem [fspa_pkg::MAX_SLOTS];
   logic [fspa_pkg::LINK_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fixed_slot_pool_allocator.sv @@
// Channel  Direction  Handshake              Word
// req      in         req_valid / req_stall  req_type, req_free_slot
// rsp      out        rsp_valid / rsp_stall  ok, error code, slot, byte offset, count
// csr      in         csr_we                 csr_index, csr_wdata
//
// A free, a bump allocate or a rejected request has its result registered at
// the edge after acceptance, and the next word can enter then.
// An allocate from the free list finishes in ST_POP, from the registered read
// of the link memory that yields the new list head; no request enters meanwhile.
// Reset is synchronous; the link memory needs no clearing pass.
// A stalled result holds the input stalled until the result is taken.
module fixed_slot_pool_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [fspa_pkg::SLOT_W-1:0]         req_free_slot,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic [1:0]                          rsp_error_code,
   output logic [fspa_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic [fspa_pkg::OFS_W-1:0]          rsp_byte_offset,
   output logic [fspa_pkg::CNT_W-1:0]          rsp_in_use_count,
   input  logic                                csr_we,
   input  logic [fspa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fspa_pkg::CHUNK_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [fspa_pkg::CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [fspa_pkg::CNT_W-1:0]   limit_cfg_ff, limit_cfg_in;

   // Allocator state.
   fspa_pkg::state_type         state_ff, state_in;
   logic [fspa_pkg::CNT_W-1:0]  bump_ff, bump_in;
   logic [fspa_pkg::SLOT_W-1:0] head_ff, head_in;
   logic                        nonempty_ff, nonempty_in;
   logic [fspa_pkg::CNT_W-1:0]  used_ff, used_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         ok_ff, ok_in;
   logic [1:0]                   err_ff, err_in;
   logic [fspa_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [fspa_pkg::OFS_W-1:0]   ofs_ff, ofs_in;
   logic [fspa_pkg::CNT_W-1:0]   count_ff, count_in;

   // Link memory interface.
   fspa_pkg::link_wr_type        link_wr;
   fspa_pkg::link_rd_type        link_rd;
   logic [fspa_pkg::LINK_W-1:0]  link_data;

   logic                         accept;
   logic                         out_free;
   logic                         load;
   logic [fspa_pkg::CNT_W-1:0]   limit;
   logic [fspa_pkg::CHUNK_W-1:0] stride;
   logic [fspa_pkg::OFS_W-1:0]   product;

   fspa_link_ram u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd      (link_rd),
      .rd_data (link_data)
   );

   // Configuration writes.
   always_comb begin
      chunk_in     = chunk_ff;
      limit_cfg_in = limit_cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            fspa_pkg::CSR_CHUNK_BYTES: chunk_in     = csr_wdata;
            fspa_pkg::CSR_SLOT_LIMIT:  limit_cfg_in = csr_wdata[fspa_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Usable limit and slot stride.
   assign limit  = (limit_cfg_ff > fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS)) ?
                   fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS) : limit_cfg_ff;
   assign stride = (chunk_ff < fspa_pkg::CHUNK_W'(fspa_pkg::MIN_STRIDE)) ?
                   fspa_pkg::CHUNK_W'(fspa_pkg::MIN_STRIDE) : chunk_ff;
   assign product = fspa_pkg::OFS_W'(slot_in) * fspa_pkg::OFS_W'(stride);

   // Handshakes.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != fspa_pkg::ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   // Request decode, free-list update and result build.
   always_comb begin
      state_in     = state_ff;
      bump_in      = bump_ff;
      head_in      = head_ff;
      nonempty_in  = nonempty_ff;
      used_in      = used_ff;
      load         = 1'b0;
      ok_in        = 1'b0;
      err_in       = fspa_pkg::ERR_NONE;
      slot_in      = '0;
      link_wr.en   = 1'b0;
      link_wr.addr = req_free_slot;
      link_wr.data = {nonempty_ff, head_ff};
      link_rd.en   = 1'b0;
      link_rd.addr = head_ff;

      unique case (state_ff)
         fspa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == fspa_pkg::REQ_ALLOC) begin
                  if (used_ff >= limit) begin
                     load   = 1'b1;
                     err_in = fspa_pkg::ERR_EXHAUSTED;
                  end else if (nonempty_ff) begin
                     // Fetch the link of the head slot; finish in ST_POP once the output is free.
                     link_rd.en = 1'b1;
                     state_in   = fspa_pkg::ST_POP;
                  end else if (bump_ff >= limit) begin
                     load   = 1'b1;
                     err_in = fspa_pkg::ERR_EXHAUSTED;
                  end else begin
                     load    = 1'b1;
                     ok_in   = 1'b1;
                     slot_in = bump_ff[fspa_pkg::SLOT_W-1:0];
                     bump_in = bump_ff + fspa_pkg::CNT_W'(1);
                     used_in = used_ff + fspa_pkg::CNT_W'(1);
                  end
               end else begin
                  if (used_ff == '0) begin
                     load   = 1'b1;
                     err_in = fspa_pkg::ERR_NONE_USED;
                  end else begin
                     // Push the freed slot onto the list.
                     link_wr.en  = 1'b1;
                     load        = 1'b1;
                     ok_in       = 1'b1;
                     slot_in     = req_free_slot;
                     head_in     = req_free_slot;
                     nonempty_in = 1'b1;
                     used_in     = used_ff - fspa_pkg::CNT_W'(1);
                  end
               end
            end
         end
         fspa_pkg::ST_POP: begin
            if (out_free) begin
               load        = 1'b1;
               ok_in       = 1'b1;
               slot_in     = head_ff;
               head_in     = link_data[fspa_pkg::SLOT_W-1:0];
               nonempty_in = link_data[fspa_pkg::SLOT_W];
               used_in     = used_ff + fspa_pkg::CNT_W'(1);
               state_in    = fspa_pkg::ST_IDLE;
            end
         end
         default: state_in = fspa_pkg::ST_IDLE;
      endcase

      ofs_in       = ok_in ? product : '0;
      count_in     = used_in;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fspa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= fspa_pkg::CHUNK_RESET;
         limit_cfg_ff <= fspa_pkg::LIMIT_RESET;
         bump_ff      <= '0;
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chunk_ff     <= chunk_in;
         limit_cfg_ff <= limit_cfg_in;
         bump_ff      <= bump_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff    <= ok_in;
         err_ff   <= err_in;
         slot_ff  <= slot_in;
         ofs_ff   <= ofs_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = ok_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_slot_index   = slot_ff;
   assign rsp_byte_offset  = ofs_ff;
   assign rsp_in_use_count = count_ff;

endmodule

@@ rtl/core/fspa_checker.sv @@
module fspa_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_ok,
   input  logic [1:0]                          rsp_error_code,
   input  logic [fspa_pkg::SLOT_W-1:0]         rsp_slot_index,
   input  logic [fspa_pkg::OFS_W-1:0]          rsp_byte_offset,
   input  logic [fspa_pkg::CNT_W-1:0]          rsp_in_use_count
);

   // A carried-out request reports no error.
   a_ok_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_error_code == fspa_pkg::ERR_NONE)
      else $error("ok word carries an error code");

   // A rejected request reports an error with zero slot and offset.
   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_error_code == fspa_pkg::ERR_EXHAUSTED ||
                                rsp_error_code == fspa_pkg::ERR_NONE_USED) &&
                               rsp_slot_index == '0 && rsp_byte_offset == '0)
      else $error("rejected word has bad fields");

   // The in-use count never exceeds the pool.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_in_use_count <= fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS))
      else $error("in-use count beyond pool size");

   // A stalled word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) &&
         $stable(rsp_error_code) && $stable(rsp_slot_index) &&
         $stable(rsp_byte_offset) && $stable(rsp_in_use_count))
      else $error("stalled result word changed");

   // No word is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_ok           (rsp_ok),
   .rsp_error_code   (rsp_error_code),
   .rsp_slot_index   (rsp_slot_index),
   .rsp_byte_offset  (rsp_byte_offset),
   .rsp_in_use_count (rsp_in_use_count)
);
